[design/display_write_delta_encoder_unit_defines.svh]
// Assertion macros shared by the display write delta encoder.
`ifndef DISPLAY_WRITE_DELTA_ENCODER_UNIT_DEFINES_SVH
`define DISPLAY_WRITE_DELTA_ENCODER_UNIT_DEFINES_SVH

// Implication checked on every rising edge of clk_i outside reset.
`define DWDE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be true outside reset.
`define DWDE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[design/dwde_pkg.sv]
// Types, constants and character lookup for the display write delta encoder.
`timescale 1ns / 1ps

package dwde_pkg;

  // Display memory base and row pitch.
  localparam logic [15:0] OffsetBase = 16'h4000;
  localparam logic [16:0] RowStep    = 17'h00020;

  // Command queue between classifier and serializer.
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdPtrW  = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  // ASCII codes used by the line format.
  localparam logic [7:0] ChFull    = 8'h21; // '!'
  localparam logic [7:0] ChData    = 8'h24; // '$'
  localparam logic [7:0] ChOff     = 8'h25; // '%'
  localparam logic [7:0] ChInc     = 8'h26; // '&'
  localparam logic [7:0] ChRow     = 8'h3D; // '='
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChUpperA  = 8'h41;

  // Line kinds chosen by the classifier.
  typedef enum logic [2:0] {
    KIND_FULL,
    KIND_INC,
    KIND_ROW,
    KIND_OFF,
    KIND_DATA
  } line_kind_e;

  typedef struct packed {
    logic [15:0] write_address;
    logic [15:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_item_t;

  typedef struct packed {
    line_kind_e  kind;
    logic [15:0] offset;
    logic [15:0] data;
  } cmd_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [CmdCntW-1:0] count;
  } fifo_stat_t;

  typedef struct packed {
    logic cmd_push;
    logic enable;
  } front_stat_t;

  typedef struct packed {
    logic busy;
    logic out_valid;
  } back_stat_t;

  // Upper-case hex digit.
  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib <= 4'd9) begin
      ch = ChZero + {4'd0, nib};
    end else begin
      ch = ChUpperA + {4'd0, nib} - 8'd10;
    end
    return ch;
  endfunction

  // Nibble of a word for digit positions one to four, most significant first.
  function automatic logic [3:0] word_nibble(input logic [15:0] w, input logic [3:0] pos);
    logic [3:0] nib;
    unique case (pos)
      4'd1:    nib = w[15:12];
      4'd2:    nib = w[11:8];
      4'd3:    nib = w[7:4];
      default: nib = w[3:0];
    endcase
    return nib;
  endfunction

  // Character at position idx of the line for a command.
  function automatic out_item_t line_char(input cmd_t cmd, input logic [3:0] idx);
    out_item_t o;
    o.out_char  = ChNewline;
    o.last_char = 1'b1;
    unique case (cmd.kind)
      KIND_FULL: begin
        if (idx == 4'd0) begin
          o = '{out_char: ChFull, last_char: 1'b0};
        end else if (idx <= 4'd4) begin
          o = '{out_char: hex_ascii(word_nibble(cmd.offset, idx)), last_char: 1'b0};
        end else if (idx <= 4'd8) begin
          o = '{out_char: hex_ascii(word_nibble(cmd.data, idx - 4'd4)), last_char: 1'b0};
        end
      end
      KIND_INC: begin
        if (idx == 4'd0) o = '{out_char: ChInc, last_char: 1'b0};
      end
      KIND_ROW: begin
        if (idx == 4'd0) o = '{out_char: ChRow, last_char: 1'b0};
      end
      KIND_OFF: begin
        if (idx == 4'd0) begin
          o = '{out_char: ChOff, last_char: 1'b0};
        end else if (idx <= 4'd4) begin
          o = '{out_char: hex_ascii(word_nibble(cmd.offset, idx)), last_char: 1'b0};
        end
      end
      KIND_DATA: begin
        if (idx == 4'd0) begin
          o = '{out_char: ChData, last_char: 1'b0};
        end else if (idx <= 4'd4) begin
          o = '{out_char: hex_ascii(word_nibble(cmd.data, idx)), last_char: 1'b0};
        end
      end
      default: begin
        o.out_char  = ChNewline;
        o.last_char = 1'b1;
      end
    endcase
    return o;
  endfunction

endpackage

[design/dwde_front.sv]
// Front end: takes display writes, keeps delta state and picks the line kind.
`timescale 1ns / 1ps

module dwde_front import dwde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        push_i,
  input  in_item_t    item_i,
  input  logic        cmd_full_i,
  output cmd_t        cmd_o,
  output front_stat_t stat_o
);

  logic        enable_q;
  logic [15:0] prev_off_q, prev_off_d;
  logic [15:0] prev_data_q, prev_data_d;
  logic        seen_q, seen_d;

  logic [15:0] offset;
  logic [16:0] prev_inc, prev_row;
  logic        accept, step_inc, step_row, same_data, send_full;

  // Offset and step compares, no wrap on the steps.
  always_comb begin
    offset    = item_i.write_address - OffsetBase;
    prev_inc  = {1'b0, prev_off_q} + 17'd1;
    prev_row  = {1'b0, prev_off_q} + RowStep;
    step_inc  = ({1'b0, offset} == prev_inc);
    step_row  = ({1'b0, offset} == prev_row);
    same_data = (item_i.write_data == prev_data_q);
    send_full = !seen_q || (offset == 16'd0) || (!same_data && !step_inc);
    accept    = push_i && !cmd_full_i;
  end

  // Classification and next state.
  always_comb begin
    cmd_o.offset = offset;
    cmd_o.data   = item_i.write_data;
    prev_off_d   = offset;
    prev_data_d  = prev_data_q;
    seen_d       = seen_q;
    priority if (send_full) begin
      cmd_o.kind  = KIND_FULL;
      prev_data_d = item_i.write_data;
      seen_d      = 1'b1;
    end else if (!same_data) begin
      cmd_o.kind  = KIND_DATA;
      prev_data_d = item_i.write_data;
    end else if (step_inc) begin
      cmd_o.kind = KIND_INC;
    end else if (step_row) begin
      cmd_o.kind = KIND_ROW;
    end else begin
      cmd_o.kind = KIND_OFF;
    end
  end

  assign stat_o.cmd_push = accept && enable_q;
  assign stat_o.enable   = enable_q;

  // Enable register and delta state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      prev_off_q  <= '0;
      prev_data_q <= '0;
      seen_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      if (accept && enable_q) begin
        prev_off_q  <= prev_off_d;
        prev_data_q <= prev_data_d;
        seen_q      <= seen_d;
      end
    end
  end

endmodule

[design/dwde_cmd_fifo.sv]
// Short command queue between the classifier and the serializer.
`timescale 1ns / 1ps

module dwde_cmd_fifo import dwde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cmd_t       wdata_i,
  input  logic       pop_i,
  output cmd_t       rdata_o,
  output fifo_stat_t stat_o
);

  cmd_t               entries_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CmdCntW-1:0] count_q;
  logic               do_push, do_pop;

  assign stat_o.full  = (count_q == CmdCntW'(CmdDepth));
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = entries_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[design/dwde_back.sv]
// Back end: walks a command one character per cycle into the output register, while that register is free or popped.
`timescale 1ns / 1ps

module dwde_back import dwde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic       cmd_empty_i,
  output logic       cmd_pop_o,
  output out_item_t  out_o,
  output logic       empty_o,
  input  logic       pop_i,
  output back_stat_t stat_o
);

  cmd_t       cmd_q;
  logic [3:0] idx_q;
  logic       busy_q;
  logic       out_valid_q;
  out_item_t  out_q;
  out_item_t  cur;
  logic       advance, done;

  // Current character and handshake with the output register.
  always_comb begin
    cur       = line_char(cmd_q, idx_q);
    advance   = busy_q && (!out_valid_q || pop_i);
    done      = advance && cur.last_char;
    cmd_pop_o = !cmd_empty_i && (!busy_q || done);
  end

  assign out_o            = out_q;
  assign empty_o          = !out_valid_q;
  assign stat_o.busy      = busy_q;
  assign stat_o.out_valid = out_valid_q;

  // Command register and character payload.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (advance) begin
      out_q <= cur;
    end
  end

  // Serializer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (advance) begin
        idx_q <= idx_q + 4'd1;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[design/display_write_delta_encoder_unit.sv]
// Top level of the display write delta encoder.
`timescale 1ns / 1ps

// Each accepted display write becomes one ASCII line of 2, 6 or 10 characters,
// delivered one character per cycle on out_item_o while the consumer pops, last_char
// marking the newline. The front end classifies a write in the cycle it is
// accepted and hands a command to a two-entry queue, so writes are taken while
// the serializer is still busy with an earlier line; sustained throughput is set
// by the serializer. With the serializer idle, the first character reaches the
// result ports through the queue, the command register and the output register.
// With the enable register at 0, writes are consumed without output or state
// change.
`include "display_write_delta_encoder_unit_defines.svh"

module display_write_delta_encoder_unit import dwde_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  cmd_t        front_cmd, fifo_cmd;
  front_stat_t front_stat;
  fifo_stat_t  fifo_stat;
  back_stat_t  back_stat;
  logic        fifo_pop;

  assign full = fifo_stat.full;

  // Classifier and delta state.
  dwde_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push),
    .item_i     (in_item_i),
    .cmd_full_i (fifo_stat.full),
    .cmd_o      (front_cmd),
    .stat_o     (front_stat)
  );

  // Command queue.
  dwde_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_stat.cmd_push),
    .wdata_i(front_cmd),
    .pop_i  (fifo_pop),
    .rdata_o(fifo_cmd),
    .stat_o (fifo_stat)
  );

  // Character serializer.
  dwde_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (fifo_cmd),
    .cmd_empty_i(fifo_stat.empty),
    .cmd_pop_o  (fifo_pop),
    .out_o      (out_item_o),
    .empty_o    (empty),
    .pop_i      (pop),
    .stat_o     (back_stat)
  );

  // Checks.
  `DWDE_ASSERT_IMP(a_push_only_enabled, front_stat.cmd_push, front_stat.enable, "command pushed while disabled")
  `DWDE_ASSERT_NEVER(a_no_pop_when_empty, fifo_pop && fifo_stat.empty, "command popped from empty queue")
  `DWDE_ASSERT_NEVER(a_count_in_range, fifo_stat.count > CmdCntW'(CmdDepth), "command queue count out of range")
  `DWDE_ASSERT_IMP(a_line_starts, front_stat.cmd_push && fifo_stat.empty && !back_stat.busy, ##3 !empty, "accepted write produced no character")
  `DWDE_ASSERT_IMP(a_result_held, back_stat.out_valid && !pop, ##1 (!empty && $stable(out_item_o)), "waiting character changed")

endmodule
